// ===== src/kmp_stream_matcher_assert.svh =====
// Assertion macros shared by the kmp_stream_matcher RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH

// same-cycle implication
`define KMP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmp_stream_matcher: assertion failed");

// next-cycle implication
`define KMP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmp_stream_matcher: assertion failed");

`endif

// ===== src/kmp_pkg.sv =====
// Shared types and constants for the KMP stream matcher.
// No dependencies; used by kmp_ctrl, kmp_dpath and kmp_stream_matcher.
package kmp_pkg;

   localparam int START_WIDTH = 32;

   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_DONE = 3'b100
   } kmp_state_type;

   typedef struct packed {
      logic accept;
      logic cmp;
      logic load;
   } kmp_cmd_type;

   typedef struct packed {
      logic no_walk;
      logic walk_end;
   } kmp_status_type;

endpackage

// ===== src/kmp_ctrl.sv =====
// Controller FSM of the KMP stream matcher: accept, failure-link walk, result hand-off.
// Depends on kmp_pkg and kmp_stream_matcher_assert.svh.
`include "kmp_stream_matcher_assert.svh"

module kmp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  kmp_pkg::kmp_status_type  status,
   output kmp_pkg::kmp_cmd_type     cmd
);

   kmp_pkg::kmp_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_free  = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         kmp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.no_walk ? kmp_pkg::ST_DONE : kmp_pkg::ST_CMP;
            end
         end
         kmp_pkg::ST_CMP: begin
            cmd.cmp = 1'b1;
            if (status.walk_end) begin
               if (out_free) begin
                  cmd.load = 1'b1;
                  state_in = kmp_pkg::ST_IDLE;
               end else begin
                  state_in = kmp_pkg::ST_DONE;
               end
            end
         end
         kmp_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = kmp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kmp_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `KMP_ASSERT_NOW(a_load_free, clock, reset, cmd.load, out_free)
   `KMP_ASSERT_NEXT(a_accept_route, clock, reset, cmd.accept && status.no_walk,
      state_ff == kmp_pkg::ST_DONE)
   `KMP_ASSERT_NEXT(a_cmp_stall, clock, reset, cmd.cmp && status.walk_end && !out_free,
      state_ff == kmp_pkg::ST_DONE && rsp_valid_ff)

endmodule

// ===== src/kmp_dpath.sv =====
// Datapath of the KMP stream matcher: pattern and failure-link memories, match state,
// text position and result registers. Depends on kmp_pkg and kmp_stream_matcher_assert.svh.
`include "kmp_stream_matcher_assert.svh"

module kmp_dpath #(
   parameter int MAX_PATTERN    = 64,
   parameter int POSITION_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kmp_pkg::kmp_cmd_type                cmd,
   output kmp_pkg::kmp_status_type             status,
   input  logic                                req_op,
   input  logic                                req_start_new,
   input  logic [7:0]                          req_symbol,
   output logic                                rsp_match_found,
   output logic [kmp_pkg::START_WIDTH-1:0]     rsp_match_start,
   output logic                                rsp_pattern_full
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam int PW = POSITION_WIDTH;
   localparam int OW = kmp_pkg::START_WIDTH;
   localparam int SW = (PW > OW) ? PW : OW;
   localparam logic [LW-1:0] MAXL = LW'(MAX_PATTERN);

   logic [7:0]    pat_mem  [MAX_PATTERN];
   logic [LW-1:0] fail_mem [MAX_PATTERN];
   logic [7:0]    pat_rd;
   logic [LW-1:0] fail_rd;

   logic          op_ff, op_in;
   logic [7:0]    sym_ff, sym_in;
   logic [LW-1:0] k_ff, k_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] bps_ff, bps_in;
   logic [LW-1:0] tms_ff, tms_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          res_found_ff, res_found_in;
   logic [OW-1:0] res_start_ff, res_start_in;
   logic          res_full_ff, res_full_in;
   logic          rsp_found_ff;
   logic [OW-1:0] rsp_start_ff;
   logic          rsp_full_ff;

   logic          clr, hit;
   logic [LW-1:0] len_eff, bps_eff, q_eff, k_step;
   logic [PW-1:0] pos_eff, start_pos;
   logic [SW-1:0] start_ext;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [7:0]    wr_sym;
   logic [LW-1:0] wr_fail;
   logic [LW-1:0] rd_prev;
   logic [IW-1:0] rd_idx, rd_prev_idx;

   always_comb begin
      op_in        = op_ff;
      sym_in       = sym_ff;
      k_in         = k_ff;
      len_in       = len_ff;
      bps_in       = bps_ff;
      tms_in       = tms_ff;
      pos_in       = pos_ff;
      res_found_in = res_found_ff;
      res_start_in = res_start_ff;
      res_full_in  = res_full_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_sym       = sym_ff;
      wr_fail      = '0;
      status       = '0;

      clr     = req_start_new;
      len_eff = clr ? '0 : len_ff;
      bps_eff = clr ? '0 : bps_ff;
      pos_eff = clr ? '0 : pos_ff;
      q_eff   = clr ? '0 : tms_ff;
      if (q_eff >= len_ff) begin
         q_eff = '0;
      end

      hit       = (pat_rd == sym_ff);
      k_step    = hit ? k_ff + LW'(1) : k_ff;
      start_pos = pos_ff - PW'(len_ff);
      start_ext = SW'(start_pos);

      if (req_op == kmp_pkg::OP_PATTERN) begin
         status.no_walk = (len_eff == MAXL) || (len_eff == '0);
      end else begin
         status.no_walk = (len_ff == '0);
      end

      if (cmd.accept) begin
         op_in        = req_op;
         sym_in       = req_symbol;
         res_found_in = 1'b0;
         res_start_in = '0;
         res_full_in  = 1'b0;
         if (req_op == kmp_pkg::OP_PATTERN) begin
            len_in = len_eff;
            bps_in = bps_eff;
            k_in   = bps_eff;
            if (clr) begin
               tms_in = '0;
            end
            if (len_eff == MAXL) begin
               res_full_in = 1'b1;
            end else if (len_eff == '0) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_sym  = req_symbol;
               wr_fail = '0;
               len_in  = LW'(1);
               bps_in  = '0;
            end
         end else begin
            pos_in = pos_eff + PW'(1);
            k_in   = q_eff;
            if (len_ff == '0) begin
               tms_in = '0;
            end
         end
      end else if (cmd.cmp) begin
         status.walk_end = hit || (k_ff == '0);
         if (!status.walk_end) begin
            k_in = fail_rd;
         end else begin
            k_in = k_step;
            if (op_ff == kmp_pkg::OP_PATTERN) begin
               wr_en   = 1'b1;
               wr_addr = len_ff[IW-1:0];
               wr_fail = k_step;
               bps_in  = k_step;
               len_in  = len_ff + LW'(1);
            end else if (k_step == len_ff) begin
               res_found_in = 1'b1;
               res_start_in = start_ext[OW-1:0];
               tms_in       = bps_ff;
            end else begin
               tms_in = k_step;
            end
         end
      end
   end

   // read address follows the next walk index, so data is ready in the compare cycle
   assign rd_prev     = k_in - LW'(1);
   assign rd_idx      = k_in[IW-1:0];
   assign rd_prev_idx = (k_in == '0) ? '0 : rd_prev[IW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem[wr_addr]  <= wr_sym;
         fail_mem[wr_addr] <= wr_fail;
      end
      pat_rd  <= pat_mem[rd_idx];
      fail_rd <= fail_mem[rd_prev_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         bps_ff <= '0;
         tms_ff <= '0;
         pos_ff <= '0;
      end else begin
         len_ff <= len_in;
         bps_ff <= bps_in;
         tms_ff <= tms_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sym_ff       <= sym_in;
      k_ff         <= k_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      res_full_ff  <= res_full_in;
      if (cmd.load) begin
         rsp_found_ff <= res_found_in;
         rsp_start_ff <= res_start_in;
         rsp_full_ff  <= res_full_in;
      end
   end

   assign rsp_match_found  = rsp_found_ff;
   assign rsp_match_start  = rsp_start_ff;
   assign rsp_pattern_full = rsp_full_ff;

   `KMP_ASSERT_NOW(a_walk_range, clock, reset, cmd.cmp, k_ff < len_ff)
   `KMP_ASSERT_NOW(a_text_state, clock, reset, 1'b1, tms_ff == '0 || tms_ff < len_ff)
   `KMP_ASSERT_NOW(a_len_cap, clock, reset, 1'b1, len_ff <= MAXL)

endmodule

// ===== src/kmp_stream_matcher.sv =====
// Top level of the streaming Knuth-Morris-Pratt matcher.
// Depends on kmp_pkg, kmp_ctrl and kmp_dpath.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    req_op, req_start_new, req_symbol
//   rsp_      out        rsp_valid/rsp_ready    rsp_match_found, rsp_match_start,
//                                               rsp_pattern_full
//
// One item at a time. A pattern or text byte is accepted in ST_IDLE; ST_CMP then
// compares and follows failure links, using the registered pattern/link memory read,
// until a hit or index zero. Empty pattern, first pattern byte, full store: no ST_CMP.
// A finished result sits in the output register; the next item is taken meanwhile.
// If that register is still held, the new result waits and req_ready stays low.
// Reset (synchronous) empties the pattern and zeroes match state and text position.
module kmp_stream_matcher #(
   parameter int MAX_PATTERN    = 64,
   parameter int POSITION_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic                            req_start_new,
   input  logic [7:0]                      req_symbol,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_match_found,
   output logic [kmp_pkg::START_WIDTH-1:0] rsp_match_start,
   output logic                            rsp_pattern_full
);

   kmp_pkg::kmp_cmd_type    cmd;
   kmp_pkg::kmp_status_type status;

   kmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kmp_dpath #(
      .MAX_PATTERN    (MAX_PATTERN),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_start_new    (req_start_new),
      .req_symbol       (req_symbol),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_start  (rsp_match_start),
      .rsp_pattern_full (rsp_pattern_full)
   );

endmodule
